>>> rtl/http_request_type_classifier_defines.svh
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef HTTP_REQUEST_TYPE_CLASSIFIER_DEFINES_SVH
`define HTTP_REQUEST_TYPE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HRTC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HRTC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hrtc_pkg.sv
`timescale 1ns / 1ps

package hrtc_pkg;

    // Default number of extension characters kept.
    localparam int EXT_CHARS_DEF = 4;

    // Type table: nine known extensions and the default index.
    localparam int TYPE_COUNT = 9;
    localparam int TYPE_CHARS = 4;
    localparam logic [3:0] TYPE_DEFAULT = 4'd9;

    localparam logic [7:0] TYPE_EXT [TYPE_COUNT][TYPE_CHARS] = '{
        '{"h", "t", "m", "l"},
        '{"h", "t", "m", 8'h00},
        '{"t", "x", "t", 8'h00},
        '{"c", "s", "s", 8'h00},
        '{"p", "n", "g", 8'h00},
        '{"j", "p", "g", 8'h00},
        '{"j", "p", "e", "g"},
        '{"g", "i", "f", 8'h00},
        '{"i", "c", "o", 8'h00}
    };
    localparam int TYPE_LEN [TYPE_COUNT] = '{4, 3, 3, 3, 3, 3, 4, 3, 3};

    // Method word and the characters the parser reacts to.
    localparam logic [7:0] METHOD_WORD [3] = '{"G", "E", "T"};
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] HEX_ALPHA  = 8'h41;
    localparam logic [7:0] HEX_CASE_MASK = 8'hDF;
    localparam logic [7:0] HEX_DIGIT0 = 8'h30;

    // What the parser reports for one processed word.
    typedef struct packed {
        logic       emit;
        logic [3:0] type_index;
        logic       saw_get;
    } hrtc_result_t;

    // Unchecked hex digit value, wrapping in eight bits.
    function automatic logic [7:0] hex_nibble(input logic [7:0] c);
        if (c >= HEX_ALPHA)
            return (c & HEX_CASE_MASK) - HEX_ALPHA + 8'd10;
        return c - HEX_DIGIT0;
    endfunction

endpackage

>>> rtl/hrtc_parser.sv
`timescale 1ns / 1ps

module hrtc_parser #(
    parameter int EXT_CHARS = hrtc_pkg::EXT_CHARS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_input,
    output hrtc_pkg::hrtc_result_t result
);
    import hrtc_pkg::*;

    localparam int TW   = 8 * EXT_CHARS;
    localparam int LW   = $clog2(EXT_CHARS + 2);
    localparam int WIDE = (EXT_CHARS > TYPE_CHARS) ? EXT_CHARS : TYPE_CHARS;

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_WORD,
        PH_SPACES,
        PH_PATH,
        PH_IGNORE
    } phase_t;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_HIGH,
        ESC_LOW
    } esc_t;

    phase_t     phase_reg, phase_next;
    logic [1:0] method_count_reg, method_count_next;
    logic [1:0] blank_reg, blank_next;
    esc_t       esc_reg, esc_next;
    logic [7:0] esc_high_reg, esc_high_next;
    logic [TW-1:0] ext_text_reg, ext_text_next;
    logic [LW-1:0] ext_len_reg, ext_len_next;
    logic       ext_open_reg, ext_open_next;
    logic [3:0] held_index_reg, held_index_next;
    logic       held_locked_reg, held_locked_next;
    logic       get_seen_reg, get_seen_next;

    logic       in_path;
    logic       finish;
    logic       new_line;
    logic       emit;
    logic       pb_en;
    logic       pc_en;
    logic [7:0] pc;
    logic [7:0] nib_high;
    logic [7:0] nib_low;
    logic [7:0] decoded;
    logic [3:0] lookup_index;

    // Table index of the held extension, first match wins.
    function automatic logic [3:0] lookup_ext(input logic [LW-1:0] len,
                                              input logic [TW-1:0] text);
        logic [8*WIDE-1:0] wide;
        logic [3:0]        idx;
        logic              found;
        logic              same;
        wide  = (8*WIDE)'(text);
        idx   = TYPE_DEFAULT;
        found = 1'b0;
        if (len <= LW'(EXT_CHARS)) begin
            for (int i = 0; i < TYPE_COUNT; i++) begin
                same = (len == LW'(TYPE_LEN[i]));
                for (int k = 0; k < TYPE_CHARS; k++) begin
                    if (k < TYPE_LEN[i] && wide[8*k +: 8] != TYPE_EXT[i][k])
                        same = 1'b0;
                end
                if (same && !found) begin
                    idx   = 4'(i);
                    found = 1'b1;
                end
            end
        end
        return idx;
    endfunction

    // Escape decode and extension lookup work on the current state.
    assign nib_high     = hex_nibble(esc_high_reg);
    assign nib_low      = hex_nibble(data_byte);
    assign decoded      = {nib_high[3:0], 4'b0000} | nib_low;
    assign lookup_index = lookup_ext(ext_len_reg, ext_text_reg);
    assign in_path      = (phase_reg == PH_WORD) || (phase_reg == PH_SPACES) ||
                          (phase_reg == PH_PATH);

    // Next state for one header word.
    always_comb
    begin
        phase_next        = phase_reg;
        method_count_next = method_count_reg;
        blank_next        = blank_reg;
        esc_next          = esc_reg;
        esc_high_next     = esc_high_reg;
        ext_text_next     = ext_text_reg;
        ext_len_next      = ext_len_reg;
        ext_open_next     = ext_open_reg;
        held_index_next   = held_index_reg;
        held_locked_next  = held_locked_reg;
        get_seen_next     = get_seen_reg;
        finish   = 1'b0;
        new_line = 1'b0;
        emit     = 1'b0;
        pb_en    = 1'b0;
        pc_en    = 1'b0;
        pc       = data_byte;

        // Line and method tracking.
        if (step) begin
            if (end_of_input) begin
                finish = in_path;
                emit   = 1'b1;
            end else if (data_byte == CH_LF) begin
                finish = in_path;
                if (blank_reg < 2'd2)
                    emit = 1'b1;
                else
                    new_line = 1'b1;
            end else begin
                blank_next = (data_byte == CH_CR && blank_reg == 2'd0) ? 2'd1 : 2'd2;
                if (data_byte == CH_CR && in_path) begin
                    finish = 1'b1;
                end else begin
                    unique case (phase_reg)
                        PH_METHOD:
                        begin
                            if (method_count_reg != 2'd3 &&
                                data_byte == METHOD_WORD[method_count_reg]) begin
                                method_count_next = method_count_reg + 2'd1;
                                if (method_count_reg == 2'd2) begin
                                    get_seen_next = 1'b1;
                                    phase_next    = PH_WORD;
                                end
                            end else begin
                                phase_next = PH_IGNORE;
                            end
                        end
                        PH_WORD:
                        begin
                            if (data_byte == CH_SPACE)
                                phase_next = PH_SPACES;
                        end
                        PH_SPACES:
                        begin
                            if (data_byte != CH_SPACE) begin
                                phase_next = PH_PATH;
                                pb_en      = 1'b1;
                            end
                        end
                        PH_PATH:
                        begin
                            if (data_byte == CH_SPACE)
                                finish = 1'b1;
                            else
                                pb_en = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end

        // Percent decoding of a path byte.
        if (pb_en) begin
            if (data_byte == CH_NUL) begin
                finish = 1'b1;
            end else if (esc_reg == ESC_IDLE) begin
                if (data_byte == CH_PERCENT)
                    esc_next = ESC_HIGH;
                else
                    pc_en = 1'b1;
            end else if (esc_reg == ESC_HIGH) begin
                esc_high_next = data_byte;
                esc_next      = ESC_LOW;
            end else begin
                esc_next = ESC_IDLE;
                pc_en    = 1'b1;
                pc       = decoded;
            end
        end

        // Extension tracking on a decoded path character.
        if (pc_en) begin
            if (pc == CH_NUL) begin
                finish = 1'b1;
            end else if (pc == CH_DOT) begin
                ext_open_next = 1'b1;
                ext_len_next  = '0;
                ext_text_next = '0;
            end else if (pc == CH_SLASH) begin
                ext_open_next = 1'b0;
            end else if (ext_open_reg) begin
                if (ext_len_reg < LW'(EXT_CHARS)) begin
                    for (int k = 0; k < EXT_CHARS; k++) begin
                        if (ext_len_reg == LW'(k))
                            ext_text_next[8*k +: 8] = pc;
                    end
                    ext_len_next = ext_len_reg + 1'b1;
                end else begin
                    ext_len_next = LW'(EXT_CHARS + 1);
                end
            end
        end

        // End of a path: settle the held index and clear path state.
        if (finish) begin
            if (!held_locked_reg) begin
                if (!ext_open_reg) begin
                    held_index_next  = TYPE_DEFAULT;
                    held_locked_next = 1'b1;
                end else begin
                    held_index_next = lookup_index;
                end
            end
            esc_next      = ESC_IDLE;
            esc_high_next = '0;
            ext_open_next = 1'b0;
            ext_len_next  = '0;
            ext_text_next = '0;
            phase_next    = PH_IGNORE;
        end

        if (new_line) begin
            phase_next        = PH_METHOD;
            method_count_next = '0;
            blank_next        = '0;
        end

        // A finished request reports and starts over from reset.
        result.emit       = emit;
        result.type_index = held_index_next;
        result.saw_get    = get_seen_next;
        if (emit) begin
            phase_next        = PH_METHOD;
            method_count_next = '0;
            blank_next        = '0;
            esc_next          = ESC_IDLE;
            esc_high_next     = '0;
            ext_text_next     = '0;
            ext_len_next      = '0;
            ext_open_next     = 1'b0;
            held_index_next   = TYPE_DEFAULT;
            held_locked_next  = 1'b0;
            get_seen_next     = 1'b0;
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg        <= PH_METHOD;
            method_count_reg <= '0;
            blank_reg        <= '0;
            esc_reg          <= ESC_IDLE;
            esc_high_reg     <= '0;
            ext_text_reg     <= '0;
            ext_len_reg      <= '0;
            ext_open_reg     <= 1'b0;
            held_index_reg   <= TYPE_DEFAULT;
            held_locked_reg  <= 1'b0;
            get_seen_reg     <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            method_count_reg <= method_count_next;
            blank_reg        <= blank_next;
            esc_reg          <= esc_next;
            esc_high_reg     <= esc_high_next;
            ext_text_reg     <= ext_text_next;
            ext_len_reg      <= ext_len_next;
            ext_open_reg     <= ext_open_next;
            held_index_reg   <= held_index_next;
            held_locked_reg  <= held_locked_next;
            get_seen_reg     <= get_seen_next;
        end
    end

endmodule

>>> rtl/http_request_type_classifier.sv
`timescale 1ns / 1ps
// Results are registered: a word passes the input register and the parser into the result register.
// Throughput: one word per cycle while the result is not stalled; the parser state updates once per word.
// A word waits in the input register while a finished result is still unaccepted.
// Reset (rst_n low, asynchronous) empties both registers and returns the parser
// to the start of a request.

module http_request_type_classifier #(
    parameter int EXT_CHARS = hrtc_pkg::EXT_CHARS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_input,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [3:0] type_index,
    output logic       saw_get
);
    import hrtc_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   byte_reg;
    logic         eoi_reg;
    logic         advance;
    logic         result_valid_reg;
    logic [3:0]   type_index_reg;
    logic         saw_get_reg;
    hrtc_result_t step_result;

    // The held word moves on whenever the result register can take a result.
    assign advance    = in_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (item_ready) begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready) begin
            byte_reg <= data_byte;
            eoi_reg  <= end_of_input;
        end
    end

    hrtc_parser #(
        .EXT_CHARS(EXT_CHARS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .data_byte   (byte_reg),
        .end_of_input(eoi_reg),
        .result      (step_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end else if (advance && step_result.emit) begin
            result_valid_reg <= 1'b1;
        end else if (result_ready) begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_result.emit) begin
            type_index_reg <= step_result.type_index;
            saw_get_reg    <= step_result.saw_get;
        end
    end

    assign result_valid = result_valid_reg;
    assign type_index   = type_index_reg;
    assign saw_get      = saw_get_reg;

endmodule

>>> rtl/hrtc_checker.sv
`timescale 1ns / 1ps
`include "http_request_type_classifier_defines.svh"

module hrtc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic [3:0] type_index,
    input logic       saw_get
);
    import hrtc_pkg::*;

    // A result never names an index beyond the default.
    `HRTC_ASSERT_IMP(a_index_range, result_valid, type_index <= TYPE_DEFAULT, "type index out of range")

    // Without a GET line the answer is always the default type.
    `HRTC_ASSERT_IMP(a_no_get_default, result_valid && !saw_get, type_index == TYPE_DEFAULT, "default type expected without GET")

    // Input back-pressure only comes from a stalled result.
    `HRTC_ASSERT_IMP(a_ready_low_stall, !item_ready, result_valid && !result_ready, "input stalled without a stalled result")

    // A stalled result word holds its value.
    `HRTC_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(type_index) && $stable(saw_get), "stalled result changed")

endmodule

bind http_request_type_classifier hrtc_checker u_hrtc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_ready  (item_ready),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .type_index  (type_index),
    .saw_get     (saw_get)
);
